// ----- design/e2q_pkg.sv -----
// ---------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants for the Euler-angle to quaternion converter.
// ---------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_W     = 16;
	localparam int QUAT_W      = 16;
	localparam int XY_W        = 34;   // Q2.30 rotator lanes with headroom
	localparam int ACC_W       = 26;   // residual angle, 2^-16 degree units
	localparam int TRIG_W      = 32;   // final sine/cosine, Q30
	localparam int ATAN_DEPTH  = 24;
	localparam int ANGLE_LIMIT = 23040;
	localparam int NUM_LANES   = 3;    // yaw, pitch, roll

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	typedef logic signed [ACC_W-1:0] atan_tab_t [ATAN_DEPTH];

	localparam atan_tab_t ATAN_DEG16 = '{
		ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
		ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
		ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
		ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
		ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
		ACC_W'(4),       ACC_W'(2),       ACC_W'(1),      ACC_W'(0)
	};

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ACC_W-1:0] acc;
	} lane_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

endpackage

// ----- design/e2q_cell.sv -----
// ---------------------------------------------------------------------------
// e2q_cell
// One CORDIC rotation step for the three angle lanes, registered.
// ---------------------------------------------------------------------------
module e2q_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  e2q_pkg::lane_t lane_i [e2q_pkg::NUM_LANES],
	output logic           valid_o,
	output e2q_pkg::lane_t lane_o [e2q_pkg::NUM_LANES]
);
	import e2q_pkg::*;

	lane_t lane_d [NUM_LANES];
	lane_t lane_q [NUM_LANES];
	logic  valid_q;

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			if (lane_i[k].acc >= 0) begin
				lane_d[k].x   = lane_i[k].x - (lane_i[k].y >>> STEP);
				lane_d[k].y   = lane_i[k].y + (lane_i[k].x >>> STEP);
				lane_d[k].acc = lane_i[k].acc - ATAN_DEG16[STEP];
			end else begin
				lane_d[k].x   = lane_i[k].x + (lane_i[k].y >>> STEP);
				lane_d[k].y   = lane_i[k].y - (lane_i[k].x >>> STEP);
				lane_d[k].acc = lane_i[k].acc + ATAN_DEG16[STEP];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

	assign valid_o = valid_q;
	assign lane_o  = lane_q;

endmodule

// ----- design/e2q_combine.sv -----
// ---------------------------------------------------------------------------
// e2q_combine
// Pair products, triple products and rounded sums into Q1.15 components.
// ---------------------------------------------------------------------------
module e2q_combine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid_i,
	input  e2q_pkg::trig_t                   yaw_i,
	input  e2q_pkg::trig_t                   pitch_i,
	input  e2q_pkg::trig_t                   roll_i,
	output logic                             valid_o,
	output logic signed [e2q_pkg::QUAT_W-1:0] quat_w,
	output logic signed [e2q_pkg::QUAT_W-1:0] quat_x,
	output logic signed [e2q_pkg::QUAT_W-1:0] quat_y,
	output logic signed [e2q_pkg::QUAT_W-1:0] quat_z
);
	import e2q_pkg::*;

	localparam int PROD_W = 2 * TRIG_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W - 45;
	localparam logic signed [PROD_W-1:0] PAIR_HALF = PROD_W'(64'sd1 <<< 29);
	localparam logic signed [SUM_W-1:0]  OUT_HALF  = SUM_W'(66'sd1 <<< 44);
	localparam logic signed [RND_W-1:0]  Q_MAX     = RND_W'(32767);
	localparam logic signed [RND_W-1:0]  Q_MIN     = -RND_W'(32768);

	// stage 1: roll*pitch pairs, rounded to Q30
	logic signed [TRIG_W-1:0] cc_s1, ss_s1, sc_s1, cs_s1;
	trig_t                    yaw_s1;
	logic                     valid_s1;
	// stage 2: Q60 triple products
	logic signed [PROD_W-1:0] p_s2 [8];
	logic                     valid_s2;
	logic signed [PROD_W-1:0] cc_d, ss_d, sc_d, cs_d;
	logic signed [SUM_W-1:0]  sum_d [4];
	logic signed [RND_W-1:0]  rnd_d [4];
	logic signed [QUAT_W-1:0] sat_d [4];
	logic signed [QUAT_W-1:0] q_s3 [4];
	logic                     valid_s3;

	always_comb begin
		cc_d = (roll_i.c * pitch_i.c + PAIR_HALF) >>> 30;
		ss_d = (roll_i.s * pitch_i.s + PAIR_HALF) >>> 30;
		sc_d = (roll_i.s * pitch_i.c + PAIR_HALF) >>> 30;
		cs_d = (roll_i.c * pitch_i.s + PAIR_HALF) >>> 30;
	end

	always_comb begin
		sum_d[0] = SUM_W'(p_s2[0]) + SUM_W'(p_s2[1]);
		sum_d[1] = SUM_W'(p_s2[2]) - SUM_W'(p_s2[3]);
		sum_d[2] = SUM_W'(p_s2[4]) + SUM_W'(p_s2[5]);
		sum_d[3] = SUM_W'(p_s2[6]) - SUM_W'(p_s2[7]);
		for (int k = 0; k < 4; k++) begin
			rnd_d[k] = RND_W'((sum_d[k] + OUT_HALF) >>> 45);
			if (rnd_d[k] > Q_MAX) begin
				sat_d[k] = QUAT_W'(Q_MAX);
			end else if (rnd_d[k] < Q_MIN) begin
				sat_d[k] = QUAT_W'(Q_MIN);
			end else begin
				sat_d[k] = QUAT_W'(rnd_d[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1   <= TRIG_W'(cc_d);
			ss_s1   <= TRIG_W'(ss_d);
			sc_s1   <= TRIG_W'(sc_d);
			cs_s1   <= TRIG_W'(cs_d);
			yaw_s1  <= yaw_i;
			p_s2[0] <= cc_s1 * yaw_s1.c;
			p_s2[1] <= ss_s1 * yaw_s1.s;
			p_s2[2] <= sc_s1 * yaw_s1.c;
			p_s2[3] <= cs_s1 * yaw_s1.s;
			p_s2[4] <= cs_s1 * yaw_s1.c;
			p_s2[5] <= sc_s1 * yaw_s1.s;
			p_s2[6] <= cc_s1 * yaw_s1.s;
			p_s2[7] <= ss_s1 * yaw_s1.c;
			q_s3    <= sat_d;
		end
	end

	assign valid_o = valid_s3;
	assign quat_w  = q_s3[0];
	assign quat_x  = q_s3[1];
	assign quat_y  = q_s3[2];
	assign quat_z  = q_s3[3];

endmodule

// ----- design/euler_to_quaternion.sv -----
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X Euler angles (1/128 degree) to a unit quaternion in Q1.15.
// ---------------------------------------------------------------------------
// Fully pipelined: one item enters per cycle unless back pressure holds the
// pipeline, and passes through a chain of CORDIC cells (CORDIC_ITERATIONS
// of them, capped at 24), one rotation step per cell for all three angles,
// followed by three product and rounding stages. Back pressure on the output
// holds the whole pipeline.
module euler_to_quaternion #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [e2q_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic signed [e2q_pkg::ANGLE_W-1:0] pitch_angle,
	input  logic signed [e2q_pkg::ANGLE_W-1:0] roll_angle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [e2q_pkg::QUAT_W-1:0]  quat_w,
	output logic signed [e2q_pkg::QUAT_W-1:0]  quat_x,
	output logic signed [e2q_pkg::QUAT_W-1:0]  quat_y,
	output logic signed [e2q_pkg::QUAT_W-1:0]  quat_z
);
	import e2q_pkg::*;

	localparam int STEPS = (CORDIC_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_ITERATIONS;
	localparam logic signed [ANGLE_W-1:0] LIM = ANGLE_W'(ANGLE_LIMIT);

	logic                     advance;
	logic signed [ANGLE_W-1:0] ang [NUM_LANES];
	logic signed [ANGLE_W-1:0] clamped [NUM_LANES];
	lane_t                    head_lane [NUM_LANES];
	logic                     chain_valid [STEPS+1];
	lane_t                    chain_lane [STEPS+1][NUM_LANES];
	trig_t                    trig [NUM_LANES];
	logic                     comb_valid;

	// hold everything while a finished item waits downstream
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	assign ang[0] = yaw_angle;
	assign ang[1] = pitch_angle;
	assign ang[2] = roll_angle;

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			if (ang[k] > LIM) begin
				clamped[k] = LIM;
			end else if (ang[k] < -LIM) begin
				clamped[k] = -LIM;
			end else begin
				clamped[k] = ang[k];
			end
			head_lane[k].x   = CORDIC_GAIN;
			head_lane[k].y   = '0;
			head_lane[k].acc = ACC_W'(signed'({clamped[k], 8'b0}));
		end
	end

	assign chain_lane[0]  = head_lane;
	assign chain_valid[0] = in_valid;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		e2q_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.valid_i (chain_valid[i]),
			.lane_i  (chain_lane[i]),
			.valid_o (chain_valid[i+1]),
			.lane_o  (chain_lane[i+1])
		);
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			trig[k].c = TRIG_W'(chain_lane[STEPS][k].x);
			trig[k].s = TRIG_W'(chain_lane[STEPS][k].y);
		end
	end

	e2q_combine u_combine (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.valid_i (chain_valid[STEPS]),
		.yaw_i   (trig[0]),
		.pitch_i (trig[1]),
		.roll_i  (trig[2]),
		.valid_o (comb_valid),
		.quat_w  (quat_w),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z)
	);

	assign out_valid = comb_valid;

endmodule

// ----- design/e2q_checker.sv -----
// ---------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the Euler-angle to quaternion converter.
// ---------------------------------------------------------------------------
module e2q_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] quat_w,
	input logic [15:0] quat_x,
	input logic [15:0] quat_y,
	input logic [15:0] quat_z
);

	// input side stalls exactly when a result is held
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not track held output");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("held item dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z))
		else $error("held item changed");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.quat_w    (quat_w),
	.quat_x    (quat_x),
	.quat_y    (quat_y),
	.quat_z    (quat_z)
);

// ----- verif/euler_to_quaternion_tb.sv -----
// ---------------------------------------------------------------------------
// euler_to_quaternion_tb
// Drives random and corner Euler angles through the converter and checks
// every quaternion against a bit-exact CORDIC and product model.
// ---------------------------------------------------------------------------
module euler_to_quaternion_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import e2q_pkg::*;

	localparam int ITERS   = 16;
	localparam int LATENCY = ((ITERS > ATAN_DEPTH) ? ATAN_DEPTH : ITERS) + 4;

	typedef struct {
		logic signed [QUAT_W-1:0] w, x, y, z;
	} quat_t;

	class quat_scoreboard;
		quat_t pending[$];
		int    errors = 0;

		static function longint clamp_angle(logic signed [ANGLE_W-1:0] raw);
			longint a;
			a = raw;
			if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
			if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
			return a;
		endfunction

		static function void half_sincos(logic signed [ANGLE_W-1:0] raw,
				output longint c, output longint s);
			longint x, y, acc, dx, dy;
			int n;
			x = 652032874;
			y = 0;
			acc = clamp_angle(raw) * 256;
			n = (ITERS > ATAN_DEPTH) ? ATAN_DEPTH : ITERS;
			for (int i = 0; i < n; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (acc >= 0) begin
					x -= dx; y += dy; acc -= longint'(ATAN_DEG16[i]);
				end else begin
					x += dx; y -= dy; acc += longint'(ATAN_DEG16[i]);
				end
			end
			c = x;
			s = y;
		endfunction

		static function longint triple(longint a, longint b, longint c);
			longint ab;
			ab = (a * b + (longint'(1) <<< 29)) >>> 30;
			return ab * c;
		endfunction

		static function logic signed [QUAT_W-1:0] to_q15(longint q60);
			longint v;
			v = (q60 + (longint'(1) <<< 44)) >>> 45;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[QUAT_W-1:0];
		endfunction

		function void note_angles(logic signed [ANGLE_W-1:0] yaw,
				logic signed [ANGLE_W-1:0] pitch, logic signed [ANGLE_W-1:0] roll);
			longint cy, sy, cp, sp, cr, sr;
			quat_t q;
			half_sincos(yaw, cy, sy);
			half_sincos(pitch, cp, sp);
			half_sincos(roll, cr, sr);
			q.w = to_q15(triple(cr, cp, cy) + triple(sr, sp, sy));
			q.x = to_q15(triple(sr, cp, cy) - triple(cr, sp, sy));
			q.y = to_q15(triple(cr, sp, cy) + triple(sr, cp, sy));
			q.z = to_q15(triple(cr, cp, sy) - triple(sr, sp, cy));
			pending.push_back(q);
		endfunction

		function void check_quat(quat_t got);
			quat_t exp_q;
			if (pending.size() == 0) begin
				$display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
					$time, got.w, got.x, got.y, got.z);
				errors++;
				return;
			end
			exp_q = pending.pop_front();
			if (got.w !== exp_q.w) begin
				$display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, got.w);
				errors++;
			end
			if (got.x !== exp_q.x) begin
				$display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, got.x);
				errors++;
			end
			if (got.y !== exp_q.y) begin
				$display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, got.y);
				errors++;
			end
			if (got.z !== exp_q.z) begin
				$display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, got.z);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [ANGLE_W-1:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	quat_scoreboard sb = new();

	euler_to_quaternion #(.CORDIC_ITERATIONS(ITERS)) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stall, check on accept.
	always @(posedge clk) begin
		quat_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.w = quat_w; got.x = quat_x; got.y = quat_y; got.z = quat_z;
				sb.check_quat(got);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic signed [ANGLE_W-1:0] random_angle();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return ANGLE_W'($urandom_range(2 * ANGLE_LIMIT) - ANGLE_LIMIT);
		if (pick < 85)
			return ANGLE_W'($urandom());
		if (pick < 92)
			return ANGLE_W'($urandom_range(40) - 20);
		return ($urandom_range(1)) ? ANGLE_W'(ANGLE_LIMIT) : ANGLE_W'(-ANGLE_LIMIT);
	endfunction

	// Present one item and hold it until accepted.
	task automatic send_angles(logic signed [ANGLE_W-1:0] yaw,
			logic signed [ANGLE_W-1:0] pitch, logic signed [ANGLE_W-1:0] roll);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		yaw_angle   <= yaw;
		pitch_angle <= pitch;
		roll_angle  <= roll;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_angles(yaw, pitch, roll);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_angles(random_angle(), random_angle(), random_angle());
	endtask

	initial begin
		logic signed [ANGLE_W-1:0] corners[$];
		corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd23041, -16'sd23041,
			16'sh7FFF, 16'sh8000, 16'sd11520, -16'sd11520, 16'sd1, -16'sd1, 16'sd5760};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero rotation, then each corner alone (even ones on yaw and on pitch, odd ones on roll), then all axes.
		send_angles('0, '0, '0);
		foreach (corners[i]) begin
			if (i % 2 == 0) begin
				send_angles(corners[i], '0, '0);
				send_angles('0, corners[i], '0);
			end else begin
				send_angles('0, '0, corners[i]);
			end
		end
		send_angles(16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_angles(-16'sd23040, 16'sd23040, -16'sd23040);

		send_idle_pct = 26; recv_idle_pct = 72;
		random_phase(280);
		// Hold off until the pipeline has drained.
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		send_idle_pct = 72; recv_idle_pct = 26;
		random_phase(280);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(270);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
